// ----- design/bcdrtc_pkg.sv -----
`default_nettype none

package bcdrtc_pkg;

	// Register file geometry
	localparam int REG_COUNT = 16;
	localparam int REG_AW = $clog2(REG_COUNT);

	// Prescaler width and the number of ticks in one second
	localparam int PRESC_W = 10;
	localparam int TICKS_PER_SECOND = 10;

	// Bus commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_PTR   = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Register map
	localparam logic [REG_AW-1:0] REG_CTRL1   = REG_AW'(0);
	localparam logic [REG_AW-1:0] REG_CTRL2   = REG_AW'(1);
	localparam logic [REG_AW-1:0] REG_SEC     = REG_AW'(2);
	localparam logic [REG_AW-1:0] REG_MIN     = REG_AW'(3);
	localparam logic [REG_AW-1:0] REG_HOUR    = REG_AW'(4);
	localparam logic [REG_AW-1:0] REG_DAY     = REG_AW'(5);
	localparam logic [REG_AW-1:0] REG_WDAY    = REG_AW'(6);
	localparam logic [REG_AW-1:0] REG_MON     = REG_AW'(7);
	localparam logic [REG_AW-1:0] REG_YEAR    = REG_AW'(8);
	localparam logic [REG_AW-1:0] REG_AL_MIN  = REG_AW'(9);
	localparam logic [REG_AW-1:0] REG_AL_HOUR = REG_AW'(10);
	localparam logic [REG_AW-1:0] REG_AL_DAY  = REG_AW'(11);
	localparam logic [REG_AW-1:0] REG_AL_WDAY = REG_AW'(12);

	// Control bits and field masks
	localparam logic [7:0] STOP_BIT   = 8'h20;
	localparam logic [7:0] AF_BIT     = 8'h08;
	localparam logic [7:0] AIE_BIT    = 8'h02;
	localparam logic [7:0] AL_DIS_BIT = 8'h80;
	localparam logic [7:0] MASK_SEC   = 8'h7F;
	localparam logic [7:0] MASK_MIN   = 8'h7F;
	localparam logic [7:0] MASK_HOUR  = 8'h3F;
	localparam logic [7:0] MASK_DAY   = 8'h3F;
	localparam logic [7:0] MASK_WDAY  = 8'h07;
	localparam logic [7:0] MASK_MON   = 8'h1F;

	// Bus word and result word
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} bus_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       alarm_flag;
		logic       alarm_irq;
	} result_word_t;

	// Time and calendar registers, as stored
	typedef struct packed {
		logic [7:0] sec;
		logic [7:0] min;
		logic [7:0] hour;
		logic [7:0] day;
		logic [7:0] wday;
		logic [7:0] mon;
		logic [7:0] year;
	} cal_t;

	// Alarm registers, as stored
	typedef struct packed {
		logic [7:0] min;
		logic [7:0] hour;
		logic [7:0] day;
		logic [7:0] wday;
	} alarm_regs_t;

	// Decode two BCD digits as tens*10 + units, digits above nine included.
	function automatic logic [7:0] bcd_get(input logic [7:0] v);
		logic [7:0] tens;
		logic [7:0] units;
		tens  = {4'b0, v[7:4]};
		units = {4'b0, v[3:0]};
		return (tens << 3) + (tens << 1) + units;
	endfunction

	// Encode a binary value as two BCD digits; the tens digit keeps its low four bits.
	function automatic logic [7:0] bcd_put(input logic [7:0] v);
		logic [4:0] tens;
		logic [7:0] units;
		tens = 5'd0;
		for (int i = 1; i < 26; i++) begin
			if (v >= 8'(i * 10)) begin
				tens = 5'(i);
			end
		end
		units = v - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
		return {tens[3:0], units[3:0]};
	endfunction

endpackage

`default_nettype wire

// ----- design/bcd_calendar_rtc_with_alarm_core.sv -----
`default_nettype none

// Channel   Direction  Word type       Handshake
// cmd       in         bus_word_t      cmd_valid / cmd_ready
// rsp       out        result_word_t   rsp_valid / rsp_ready
//
// Each bus word gives exactly one result word: it is first held in the input register,
// then the update runs and its result is captured in the result register.
// A word can be accepted every cycle; the input register and the result register
// hold one word each, so the command side stalls only when both are full.
// Reset clears the register file, the pointer, the prescaler and both valid flags.

module bcd_calendar_rtc_with_alarm_core
	import bcdrtc_pkg::*;
#(
	parameter int TICKS_PER_SECOND = bcdrtc_pkg::TICKS_PER_SECOND
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  bus_word_t    cmd_word,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output result_word_t rsp_word
);

	logic         valid_s1;
	bus_word_t    word_s1;
	logic         step_en;
	result_word_t result;
	logic         rsp_valid_q;
	result_word_t rsp_word_q;

	// The held word is processed whenever the result register can take its result.
	assign step_en   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || step_en;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			word_s1 <= cmd_word;
		end
	end

	bcdrtc_regs #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.word    (word_s1),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			rsp_word_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

`default_nettype wire

// ----- design/bcdrtc_advance.sv -----
`default_nettype none

module bcdrtc_advance
	import bcdrtc_pkg::*;
(
	input  cal_t cur,
	output cal_t nxt
);

	logic [7:0] sec, min, hour, day, mon, year;
	logic [2:0] wday;
	logic [7:0] mdays;
	logic       sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap;
	logic [7:0] sec_n, min_n, hour_n, day_n, mon_n, year_n;
	logic [2:0] wday_n;

	// Decode the stored digits
	always_comb begin
		sec  = bcd_get(cur.sec & MASK_SEC);
		min  = bcd_get(cur.min & MASK_MIN);
		hour = bcd_get(cur.hour & MASK_HOUR);
		day  = bcd_get(cur.day & MASK_DAY);
		wday = cur.wday[2:0];
		mon  = bcd_get(cur.mon & MASK_MON);
		year = bcd_get(cur.year);
	end

	// Length of the current month; every fourth year is a leap year.
	always_comb begin
		if (mon == 8'd2) begin
			mdays = (year[1:0] == 2'b00) ? 8'd29 : 8'd28;
		end else if (mon == 8'd4 || mon == 8'd6 || mon == 8'd9 || mon == 8'd11) begin
			mdays = 8'd30;
		end else begin
			mdays = 8'd31;
		end
	end

	// Carry chain from seconds to years
	always_comb begin
		sec_wrap  = (sec >= 8'd59);
		min_wrap  = sec_wrap && (min >= 8'd59);
		hour_wrap = min_wrap && (hour >= 8'd23);
		day_wrap  = hour_wrap && (day >= mdays);
		mon_wrap  = day_wrap && (mon >= 8'd12);

		sec_n  = sec_wrap ? 8'd0 : sec + 8'd1;
		min_n  = !sec_wrap ? min : (min >= 8'd59 ? 8'd0 : min + 8'd1);
		hour_n = !min_wrap ? hour : (hour >= 8'd23 ? 8'd0 : hour + 8'd1);
		wday_n = !hour_wrap ? wday : (wday >= 3'd6 ? 3'd0 : wday + 3'd1);
		day_n  = !hour_wrap ? day : (day >= mdays ? 8'd1 : day + 8'd1);
		mon_n  = !day_wrap ? mon : (mon >= 8'd12 ? 8'd1 : mon + 8'd1);
		year_n = !mon_wrap ? year : (year >= 8'd99 ? 8'd0 : year + 8'd1);
	end

	// Re-encode every field as clean BCD
	always_comb begin
		nxt.sec  = bcd_put(sec_n);
		nxt.min  = bcd_put(min_n);
		nxt.hour = bcd_put(hour_n);
		nxt.day  = bcd_put(day_n);
		nxt.wday = {5'b0, wday_n};
		nxt.mon  = bcd_put(mon_n);
		nxt.year = bcd_put(year_n);
	end

endmodule

`default_nettype wire

// ----- design/bcdrtc_alarm.sv -----
`default_nettype none

module bcdrtc_alarm
	import bcdrtc_pkg::*;
(
	input  cal_t        cal,
	input  alarm_regs_t al,
	output logic        hit
);

	logic [3:0] en;
	logic [3:0] match;

	// A field takes part when its disable bit is clear; at least one must take part, and all taking part must match.
	always_comb begin
		en[0] = (al.min & AL_DIS_BIT) == 8'h00;
		en[1] = (al.hour & AL_DIS_BIT) == 8'h00;
		en[2] = (al.day & AL_DIS_BIT) == 8'h00;
		en[3] = (al.wday & AL_DIS_BIT) == 8'h00;
		match[0] = (al.min & MASK_MIN) == (cal.min & MASK_MIN);
		match[1] = (al.hour & MASK_HOUR) == (cal.hour & MASK_HOUR);
		match[2] = (al.day & MASK_DAY) == (cal.day & MASK_DAY);
		match[3] = (al.wday & MASK_WDAY) == (cal.wday & MASK_WDAY);
		hit = (|en) && (&(match | ~en));
	end

endmodule

`default_nettype wire

// ----- design/bcdrtc_regs.sv -----
`default_nettype none

module bcdrtc_regs
	import bcdrtc_pkg::*;
#(
	parameter int TICKS_PER_SECOND = bcdrtc_pkg::TICKS_PER_SECOND
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_en,
	input  bus_word_t    word,
	output result_word_t result
);

	localparam logic [PRESC_W-1:0] TPS = PRESC_W'(TICKS_PER_SECOND);

	logic [7:0]         regs_q [REG_COUNT];
	logic [7:0]         regs_d [REG_COUNT];
	logic [REG_AW-1:0]  ptr_q, ptr_d;
	logic [PRESC_W-1:0] presc_q, presc_d;
	logic [PRESC_W-1:0] presc_inc;
	logic               period_end;
	logic               stopped;
	cal_t               cal_cur, cal_adv, cal_eval;
	alarm_regs_t        al;
	logic               alarm_hit;
	logic [7:0]         rd;

	// Current calendar and alarm fields
	always_comb begin
		cal_cur.sec  = regs_q[REG_SEC];
		cal_cur.min  = regs_q[REG_MIN];
		cal_cur.hour = regs_q[REG_HOUR];
		cal_cur.day  = regs_q[REG_DAY];
		cal_cur.wday = regs_q[REG_WDAY];
		cal_cur.mon  = regs_q[REG_MON];
		cal_cur.year = regs_q[REG_YEAR];
		al.min       = regs_q[REG_AL_MIN];
		al.hour      = regs_q[REG_AL_HOUR];
		al.day       = regs_q[REG_AL_DAY];
		al.wday      = regs_q[REG_AL_WDAY];
	end

	bcdrtc_advance u_advance (
		.cur (cal_cur),
		.nxt (cal_adv)
	);

	// The alarm compares against the advanced time, or the held time while stopped.
	assign stopped  = (regs_q[REG_CTRL1] & STOP_BIT) != 8'h00;
	assign cal_eval = stopped ? cal_cur : cal_adv;

	bcdrtc_alarm u_alarm (
		.cal (cal_eval),
		.al  (al),
		.hit (alarm_hit)
	);

	// Prescaler: counts every tick, stopped or not
	assign presc_inc  = presc_q + PRESC_W'(1);
	assign period_end = (presc_inc >= TPS);

	// Next state of the register file, pointer and prescaler
	always_comb begin
		for (int i = 0; i < REG_COUNT; i++) begin
			regs_d[i] = regs_q[i];
		end
		ptr_d   = ptr_q;
		presc_d = presc_q;
		rd      = 8'h00;
		case (word.cmd)
			CMD_TICK: begin
				presc_d = period_end ? '0 : presc_inc;
				if (period_end) begin
					if (!stopped) begin
						regs_d[REG_SEC]  = cal_adv.sec;
						regs_d[REG_MIN]  = cal_adv.min;
						regs_d[REG_HOUR] = cal_adv.hour;
						regs_d[REG_DAY]  = cal_adv.day;
						regs_d[REG_WDAY] = cal_adv.wday;
						regs_d[REG_MON]  = cal_adv.mon;
						regs_d[REG_YEAR] = cal_adv.year;
					end
					if (alarm_hit) begin
						regs_d[REG_CTRL2] = regs_q[REG_CTRL2] | AF_BIT;
					end
				end
			end
			CMD_PTR: begin
				ptr_d = word.data_byte[REG_AW-1:0];
			end
			CMD_WRITE: begin
				regs_d[ptr_q] = word.data_byte;
				ptr_d         = ptr_q + REG_AW'(1);
			end
			default: begin
				rd    = regs_q[ptr_q];
				ptr_d = ptr_q + REG_AW'(1);
			end
		endcase
	end

	// Result word reflects control register two after the step.
	always_comb begin
		result.read_data  = rd;
		result.alarm_flag = (regs_d[REG_CTRL2] & AF_BIT) != 8'h00;
		result.alarm_irq  = ((regs_d[REG_CTRL2] & AF_BIT) != 8'h00) &&
			((regs_d[REG_CTRL2] & AIE_BIT) != 8'h00);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= 8'h00;
			end
			ptr_q   <= '0;
			presc_q <= '0;
		end else if (step_en) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= regs_d[i];
			end
			ptr_q   <= ptr_d;
			presc_q <= presc_d;
		end
	end

endmodule

`default_nettype wire
